[hdl/sha1_pkg.sv]
// ---------------------------------------------------------------------------
// sha1 package
// types, constants and round functions shared by the sha1 engine modules
// ---------------------------------------------------------------------------
package sha1_pkg;

   localparam int WORD_W     = 32;
   localparam int BYTE_W     = 8;
   localparam int POS_W      = 6;
   localparam int ROUND_W    = 7;
   localparam int WIDX_W     = 3;
   localparam int LEN_W      = 64;
   localparam int CHAIN_N    = 5;
   localparam int BLOCK_N    = 16;

   // request opcodes
   localparam logic OP_ABSORB = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   localparam logic [POS_W-1:0]   POS_LAST    = 6'd63;
   localparam logic [POS_W-1:0]   POS_LENGTH  = 6'd56;
   localparam logic [ROUND_W-1:0] ROUND_LAST  = 7'd79;
   localparam logic [WIDX_W-1:0]  WIDX_LAST   = 3'd4;
   localparam logic [BYTE_W-1:0]  PAD_MARK    = 8'h80;
   localparam logic [LEN_W-1:0]   BITS_PER_BYTE = 64'd8;

   localparam logic [WORD_W-1:0] ROUND_K0 = 32'h5a827999;
   localparam logic [WORD_W-1:0] ROUND_K1 = 32'h6ed9eba1;
   localparam logic [WORD_W-1:0] ROUND_K2 = 32'h8f1bbcdc;
   localparam logic [WORD_W-1:0] ROUND_K3 = 32'hca62c1d6;

   localparam logic [WORD_W-1:0] INIT_WORDS [CHAIN_N] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_ADD,
      ST_EMIT
   } sha1_state_type;

   typedef enum logic [1:0] {
      SRC_DATA,
      SRC_MARK,
      SRC_ZERO
   } sha1_src_type;

   typedef struct packed {
      logic                put_byte;
      sha1_src_type        byte_src;
      logic                count_bits;
      logic                put_length;
      logic                round_en;
      logic [ROUND_W-1:0]  round_idx;
      logic                add_chain;
      logic                reinit;
      logic [WIDX_W-1:0]   word_sel;
   } sha1_cmd_type;

   typedef struct packed {
      logic at_end;
      logic at_length;
   } sha1_status_type;

   function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] idx);
      logic [WORD_W-1:0] k;
      if (idx < 7'd20) begin
         k = ROUND_K0;
      end else if (idx < 7'd40) begin
         k = ROUND_K1;
      end else if (idx < 7'd60) begin
         k = ROUND_K2;
      end else begin
         k = ROUND_K3;
      end
      return k;
   endfunction

   function automatic logic [WORD_W-1:0] round_f(input logic [ROUND_W-1:0] idx,
                                                 input logic [WORD_W-1:0] b,
                                                 input logic [WORD_W-1:0] c,
                                                 input logic [WORD_W-1:0] d);
      logic [WORD_W-1:0] f;
      if (idx < 7'd20) begin
         f = (b & c) | (~b & d);
      end else if (idx < 7'd40) begin
         f = b ^ c ^ d;
      end else if (idx < 7'd60) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

endpackage

[hdl/sha1_dpath.sv]
// ---------------------------------------------------------------------------
// sha1 datapath
// block buffer with schedule window, round unit, chaining value and length
// ---------------------------------------------------------------------------
module sha1_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  sha1_pkg::sha1_cmd_type           cmd,
   input  logic [sha1_pkg::BYTE_W-1:0]      data_byte,
   output sha1_pkg::sha1_status_type        status,
   output logic [sha1_pkg::WORD_W-1:0]      digest_word
);

   logic [sha1_pkg::WORD_W-1:0] buf_ff   [sha1_pkg::BLOCK_N];
   logic [sha1_pkg::WORD_W-1:0] chain_ff [sha1_pkg::CHAIN_N];
   logic [sha1_pkg::WORD_W-1:0] chain_in [sha1_pkg::CHAIN_N];
   logic [sha1_pkg::WORD_W-1:0] work_ff  [sha1_pkg::CHAIN_N];
   logic [sha1_pkg::WORD_W-1:0] work_in  [sha1_pkg::CHAIN_N];
   logic [sha1_pkg::POS_W-1:0]  pos_ff;
   logic [sha1_pkg::POS_W-1:0]  pos_in;
   logic [sha1_pkg::LEN_W-1:0]  bits_ff;
   logic [sha1_pkg::LEN_W-1:0]  bits_in;

   logic [sha1_pkg::BYTE_W-1:0] byte_val;
   logic [4:0]                  lane_shift;
   logic [sha1_pkg::WORD_W-1:0] sched_mix;
   logic [sha1_pkg::WORD_W-1:0] sched_new;
   logic [sha1_pkg::WORD_W-1:0] round_tmp;

   // byte source
   always_comb begin
      unique case (cmd.byte_src)
         sha1_pkg::SRC_DATA: byte_val = data_byte;
         sha1_pkg::SRC_MARK: byte_val = sha1_pkg::PAD_MARK;
         sha1_pkg::SRC_ZERO: byte_val = '0;
         default:            byte_val = '0;
      endcase
   end

   // big-endian lane: byte 0 of a word sits in bits 31:24
   assign lane_shift = {~pos_ff[1:0], 3'b000};

   // schedule window: buf_ff[i] holds w[t+i]
   assign sched_mix = buf_ff[13] ^ buf_ff[8] ^ buf_ff[2] ^ buf_ff[0];
   assign sched_new = {sched_mix[30:0], sched_mix[31]};

   assign round_tmp = {work_ff[0][26:0], work_ff[0][31:27]}
                    + sha1_pkg::round_f(cmd.round_idx, work_ff[1], work_ff[2], work_ff[3])
                    + work_ff[4] + buf_ff[0] + sha1_pkg::round_k(cmd.round_idx);

   always_ff @(posedge clock) begin
      if (cmd.round_en) begin
         for (int i = 0; i < sha1_pkg::BLOCK_N - 1; i++) begin
            buf_ff[i] <= buf_ff[i+1];
         end
         buf_ff[sha1_pkg::BLOCK_N-1] <= sched_new;
      end else if (cmd.put_byte) begin
         buf_ff[pos_ff[5:2]][lane_shift +: sha1_pkg::BYTE_W] <= byte_val;
      end else if (cmd.put_length) begin
         buf_ff[14] <= bits_ff[63:32];
         buf_ff[15] <= bits_ff[31:0];
      end
   end

   // chaining value, working variables, fill position and length
   always_comb begin
      chain_in = chain_ff;
      work_in  = work_ff;
      pos_in   = pos_ff;
      bits_in  = bits_ff;
      if (cmd.reinit) begin
         chain_in = sha1_pkg::INIT_WORDS;
         work_in  = sha1_pkg::INIT_WORDS;
         pos_in   = '0;
         bits_in  = '0;
      end else begin
         if (cmd.put_byte) begin
            pos_in = pos_ff + 6'd1;
         end
         if (cmd.count_bits) begin
            bits_in = bits_ff + sha1_pkg::BITS_PER_BYTE;
         end
         if (cmd.round_en) begin
            work_in[0] = round_tmp;
            work_in[1] = work_ff[0];
            work_in[2] = {work_ff[1][1:0], work_ff[1][31:2]};
            work_in[3] = work_ff[2];
            work_in[4] = work_ff[3];
         end
         if (cmd.add_chain) begin
            for (int i = 0; i < sha1_pkg::CHAIN_N; i++) begin
               chain_in[i] = chain_ff[i] + work_ff[i];
               work_in[i]  = chain_ff[i] + work_ff[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= sha1_pkg::INIT_WORDS;
         work_ff  <= sha1_pkg::INIT_WORDS;
         pos_ff   <= '0;
         bits_ff  <= '0;
      end else begin
         chain_ff <= chain_in;
         work_ff  <= work_in;
         pos_ff   <= pos_in;
         bits_ff  <= bits_in;
      end
   end

   assign status.at_end    = (pos_ff == sha1_pkg::POS_LAST);
   assign status.at_length = (pos_ff == sha1_pkg::POS_LENGTH);

   always_comb begin
      unique case (cmd.word_sel)
         3'd0:    digest_word = chain_ff[0];
         3'd1:    digest_word = chain_ff[1];
         3'd2:    digest_word = chain_ff[2];
         3'd3:    digest_word = chain_ff[3];
         3'd4:    digest_word = chain_ff[4];
         default: digest_word = chain_ff[0];
      endcase
   end

endmodule

[hdl/sha1_ctrl.sv]
// ---------------------------------------------------------------------------
// sha1 controller
// sequences absorb, padding, compression rounds and digest output
// ---------------------------------------------------------------------------
module sha1_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_op,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sha1_pkg::WIDX_W-1:0]       rsp_word_index,
   output logic                              rsp_last,
   input  sha1_pkg::sha1_status_type         status,
   output sha1_pkg::sha1_cmd_type            cmd
);

   sha1_pkg::sha1_state_type      state_ff;
   sha1_pkg::sha1_state_type      state_in;
   logic [sha1_pkg::ROUND_W-1:0]  rnd_ff;
   logic [sha1_pkg::ROUND_W-1:0]  rnd_in;
   logic [sha1_pkg::WIDX_W-1:0]   word_ff;
   logic [sha1_pkg::WIDX_W-1:0]   word_in;
   logic                          fin_ff;
   logic                          fin_in;
   logic                          final_ff;
   logic                          final_in;
   logic                          req_take;
   logic                          rsp_take;

   assign req_take = req_valid && (state_ff == sha1_pkg::ST_IDLE);
   assign rsp_take = (state_ff == sha1_pkg::ST_EMIT) && !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sha1_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (status.at_end) begin
                  state_in = sha1_pkg::ST_ROUND;
               end else if (req_op == sha1_pkg::OP_FINISH) begin
                  state_in = sha1_pkg::ST_PAD;
               end
            end
         end
         sha1_pkg::ST_PAD: begin
            if (status.at_length || status.at_end) begin
               state_in = sha1_pkg::ST_ROUND;
            end
         end
         sha1_pkg::ST_ROUND: begin
            if (rnd_ff == sha1_pkg::ROUND_LAST) begin
               state_in = sha1_pkg::ST_ADD;
            end
         end
         sha1_pkg::ST_ADD: begin
            if (final_ff) begin
               state_in = sha1_pkg::ST_EMIT;
            end else if (fin_ff) begin
               state_in = sha1_pkg::ST_PAD;
            end else begin
               state_in = sha1_pkg::ST_IDLE;
            end
         end
         sha1_pkg::ST_EMIT: begin
            if (!rsp_stall && word_ff == sha1_pkg::WIDX_LAST) begin
               state_in = sha1_pkg::ST_IDLE;
            end
         end
         default: state_in = sha1_pkg::ST_IDLE;
      endcase
   end

   // commands and counters
   always_comb begin
      cmd          = '0;
      cmd.byte_src = sha1_pkg::SRC_ZERO;
      cmd.round_idx = rnd_ff;
      cmd.word_sel = word_ff;
      rnd_in       = rnd_ff;
      word_in      = word_ff;
      fin_in       = fin_ff;
      final_in     = final_ff;
      unique case (state_ff)
         sha1_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.put_byte = 1'b1;
               if (req_op == sha1_pkg::OP_FINISH) begin
                  cmd.byte_src = sha1_pkg::SRC_MARK;
                  fin_in       = 1'b1;
               end else begin
                  cmd.byte_src   = sha1_pkg::SRC_DATA;
                  cmd.count_bits = 1'b1;
               end
            end
         end
         sha1_pkg::ST_PAD: begin
            if (status.at_length) begin
               cmd.put_length = 1'b1;
               final_in       = 1'b1;
            end else begin
               cmd.put_byte = 1'b1;
            end
         end
         sha1_pkg::ST_ROUND: begin
            cmd.round_en = 1'b1;
            rnd_in       = (rnd_ff == sha1_pkg::ROUND_LAST) ? '0 : rnd_ff + 7'd1;
         end
         sha1_pkg::ST_ADD: begin
            cmd.add_chain = 1'b1;
         end
         sha1_pkg::ST_EMIT: begin
            if (!rsp_stall) begin
               if (word_ff == sha1_pkg::WIDX_LAST) begin
                  cmd.reinit = 1'b1;
                  word_in    = '0;
                  fin_in     = 1'b0;
                  final_in   = 1'b0;
               end else begin
                  word_in = word_ff + 3'd1;
               end
            end
         end
         default: begin
            cmd.reinit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha1_pkg::ST_IDLE;
         rnd_ff   <= '0;
         word_ff  <= '0;
         fin_ff   <= 1'b0;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
         word_ff  <= word_in;
         fin_ff   <= fin_in;
         final_ff <= final_in;
      end
   end

   assign req_stall      = (state_ff != sha1_pkg::ST_IDLE);
   assign rsp_valid      = (state_ff == sha1_pkg::ST_EMIT);
   assign rsp_word_index = word_ff;
   assign rsp_last       = (word_ff == sha1_pkg::WIDX_LAST);

   a_round_excl: assert property (@(posedge clock) disable iff (reset)
      cmd.round_en |-> !cmd.put_byte && !cmd.put_length && !cmd.add_chain)
      else $error("round step overlaps a buffer write");

   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sha1_pkg::ST_ROUND && rnd_ff == sha1_pkg::ROUND_LAST)
      |=> state_ff == sha1_pkg::ST_ADD && rnd_ff == '0)
      else $error("compression did not finish after the last round");

   a_length_in_finish: assert property (@(posedge clock) disable iff (reset)
      cmd.put_length |-> fin_ff && !final_ff)
      else $error("length written outside a finish");

   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(word_ff))
      else $error("digest beat changed while stalled");

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_op == sha1_pkg::OP_ABSORB && !status.at_end)
      |=> state_ff == sha1_pkg::ST_IDLE)
      else $error("plain absorb left idle");

   a_word_range: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> word_ff <= sha1_pkg::WIDX_LAST)
      else $error("digest word index out of range");

endmodule

[hdl/sha1_hash_engine.sv]
// an absorb beat writes one byte into the 64-byte block; a beat that fills the block then
// runs the compression (80 rounds on one shared round unit, then the chaining add)
// finish: zero padding and the bit length, one or two compressed blocks, then five
// digest beats, one per cycle when the result side does not stall
// one item is in work at a time; req_stall is high from acceptance until the work is done
// reset (synchronous, active high) loads the standard initial chaining value, zero length
// ---------------------------------------------------------------------------
// sha1 hash engine
// byte-serial SHA-1 with a controller state machine and a round datapath
// ---------------------------------------------------------------------------
module sha1_hash_engine (
   input  logic                           clock,
   input  logic                           reset,
   // request channel: one message byte or a finish per beat
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_op,
   input  logic [sha1_pkg::BYTE_W-1:0]    req_data_byte,
   // response channel: one digest word per beat
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [sha1_pkg::WORD_W-1:0]    rsp_digest_word,
   output logic [sha1_pkg::WIDX_W-1:0]    rsp_word_index,
   output logic                           rsp_last
);

   // command and status bundles between controller and datapath
   sha1_pkg::sha1_cmd_type    cmd;
   sha1_pkg::sha1_status_type status;

   // controller: absorb, padding sequence, round counter, digest beats
   sha1_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word_index (rsp_word_index),
      .rsp_last       (rsp_last),
      .status         (status),
      .cmd            (cmd)
   );

   // datapath: block buffer doubles as the 16-word schedule window,
   // working variables shift through one round per cycle
   sha1_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_data_byte),
      .status      (status),
      .digest_word (rsp_digest_word)
   );

endmodule

[test/tb_sha1_hash_engine.sv]
// ---------------------------------------------------------------------------
// sha1 hash engine testbench
// feeds byte messages and finish beats into the engine with random idle gaps
// and stalls on both sides, keeps its own sha1 model to build the expected
// digest words and checks every response beat against them in order
// ---------------------------------------------------------------------------
module tb_sha1_hash_engine;
   timeunit 1ns;
   timeprecision 1ps;

   // request opcodes
   localparam logic OP_ABSORB = sha1_pkg::OP_ABSORB;
   localparam logic OP_FINISH = sha1_pkg::OP_FINISH;

   localparam int CYCLE_LIMIT      = 600000;
   localparam int TAIL_CYCLES      = 300;   // longer than a two-block finish
   localparam int ITEM_TARGET      = 220;
   localparam int DIGEST_TARGET    = 8;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int LONG_HOLD_AFTER  = 3;     // digests received before the long hold

   // one request beat plus the pacing that goes with it
   typedef struct {
      logic                        op;
      logic [sha1_pkg::BYTE_W-1:0] data_byte;
      int                          idle_after;  // idle cycles after acceptance
      bit                          wait_drain;  // hold back until all digests are in
   } req_beat_type;

   // one expected digest beat
   typedef struct {
      logic [sha1_pkg::WORD_W-1:0] digest_word;
      logic [sha1_pkg::WIDX_W-1:0] word_index;
      logic                        last;
   } digest_beat_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_op = OP_ABSORB;
   logic [sha1_pkg::BYTE_W-1:0] req_data_byte = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [sha1_pkg::WORD_W-1:0] rsp_digest_word;
   logic [sha1_pkg::WIDX_W-1:0] rsp_word_index;
   logic                        rsp_last;

   req_beat_type    beat_q[$];     // beats waiting to be offered
   digest_beat_type digest_q[$];   // digest words still owed by the engine

   int error_count  = 0;
   int cycle_count  = 0;
   int digests_seen = 0;

   // model state: chaining value, block buffer, fill position, length in bits
   logic [31:0] hash_words [5];
   logic [31:0] msg_block  [16];
   int          fill_pos;
   logic [63:0] msg_bits;

   sha1_hash_engine DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last        (rsp_last)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // ------------------------------------------------------------------
   // sha1 model
   // ------------------------------------------------------------------

   function automatic void hash_restart();
      hash_words[0] = 32'h67452301;
      hash_words[1] = 32'hefcdab89;
      hash_words[2] = 32'h98badcfe;
      hash_words[3] = 32'h10325476;
      hash_words[4] = 32'hc3d2e1f0;
      for (int i = 0; i < 16; i++) begin
         msg_block[i] = '0;
      end
      fill_pos = 0;
      msg_bits = '0;
   endfunction

   // big-endian byte lane within the 16-word block
   function automatic void block_put(int pos, logic [7:0] value);
      msg_block[pos / 4][(3 - pos % 4) * 8 +: 8] = value;
   endfunction

   function automatic void block_compress();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, wt, sum;
      int t;
      for (t = 0; t < 16; t++) begin
         w[t] = msg_block[t];
      end
      a = hash_words[0];
      b = hash_words[1];
      c = hash_words[2];
      d = hash_words[3];
      e = hash_words[4];
      for (t = 0; t < 80; t++) begin
         if (t < 16) begin
            wt = w[t];
         end else begin
            // schedule expansion over a 16-word circular window
            wt = w[(t + 13) % 16] ^ w[(t + 8) % 16] ^ w[(t + 2) % 16] ^ w[t % 16];
            wt = {wt[30:0], wt[31]};
            w[t % 16] = wt;
         end
         if (t < 20) begin
            f = (b & c) | (~b & d);
            k = sha1_pkg::ROUND_K0;
         end else if (t < 40) begin
            f = b ^ c ^ d;
            k = sha1_pkg::ROUND_K1;
         end else if (t < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = sha1_pkg::ROUND_K2;
         end else begin
            f = b ^ c ^ d;
            k = sha1_pkg::ROUND_K3;
         end
         sum = {a[26:0], a[31:27]} + f + e + wt + k;
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = sum;
      end
      hash_words[0] = hash_words[0] + a;
      hash_words[1] = hash_words[1] + b;
      hash_words[2] = hash_words[2] + c;
      hash_words[3] = hash_words[3] + d;
      hash_words[4] = hash_words[4] + e;
   endfunction

   // one accepted request beat; a finish queues the five digest words
   function automatic void hash_step(logic op, logic [7:0] data_byte);
      digest_beat_type word;
      if (op == OP_ABSORB) begin
         block_put(fill_pos, data_byte);
         msg_bits = msg_bits + 64'd8;   // wraps silently at 2^64
         fill_pos++;
         if (fill_pos == 64) begin
            block_compress();
            fill_pos = 0;
         end
      end else begin
         block_put(fill_pos, sha1_pkg::PAD_MARK);
         fill_pos++;
         // no room for the length: pad out and compress an extra block
         if (fill_pos > 56) begin
            while (fill_pos < 64) begin
               block_put(fill_pos, 8'h00);
               fill_pos++;
            end
            block_compress();
            fill_pos = 0;
         end
         while (fill_pos < 56) begin
            block_put(fill_pos, 8'h00);
            fill_pos++;
         end
         msg_block[14] = msg_bits[63:32];
         msg_block[15] = msg_bits[31:0];
         block_compress();
         for (int i = 0; i < 5; i++) begin
            word.digest_word = hash_words[i];
            word.word_index  = i[sha1_pkg::WIDX_W-1:0];
            word.last        = (i == 4);
            digest_q.push_back(word);
         end
         hash_restart();
      end
   endfunction

   // idle run length: mostly none or short, now and then long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(30, 80);
   endfunction

   // ------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------

   int           req_idle_left = 0;
   req_beat_type next_beat;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // beat taken at this edge: update the model
         if (req_valid && !req_stall) begin
            hash_step(req_op, req_data_byte);
         end
         // channel free unless the current beat is held by a stall
         if (!req_valid || !req_stall) begin
            if (req_idle_left > 0) begin
               req_idle_left--;
               req_valid <= 1'b0;
            end else if (beat_q.size() != 0 &&
                         (!beat_q[0].wait_drain || digest_q.size() == 0)) begin
               next_beat     = beat_q.pop_front();
               req_valid     <= 1'b1;
               req_op        <= next_beat.op;
               req_data_byte <= next_beat.data_byte;
               req_idle_left = next_beat.idle_after;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // response monitor and stall generator
   // ------------------------------------------------------------------

   int              stall_left     = 0;
   int              calm_left      = 0;
   int              hold_left      = 0;
   bit              long_hold_done = 1'b0;
   digest_beat_type owed;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (digest_q.size() == 0) begin
               $display("%0t: unexpected digest beat, actual word %h index %0d last %0b",
                        $time, rsp_digest_word, rsp_word_index, rsp_last);
               error_count++;
            end else begin
               owed = digest_q.pop_front();
               if (rsp_digest_word !== owed.digest_word) begin
                  $display("%0t: digest_word mismatch, expected %h actual %h",
                           $time, owed.digest_word, rsp_digest_word);
                  error_count++;
               end
               if (rsp_word_index !== owed.word_index) begin
                  $display("%0t: word_index mismatch, expected %0d actual %0d",
                           $time, owed.word_index, rsp_word_index);
                  error_count++;
               end
               if (rsp_last !== owed.last) begin
                  $display("%0t: last mismatch, expected %0b actual %0b",
                           $time, owed.last, rsp_last);
                  error_count++;
               end
            end
            if (rsp_last === 1'b1) begin
               digests_seen++;
            end
         end
         // long hold while a digest is pending, so the engine backs up the input
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!long_hold_done && digests_seen >= LONG_HOLD_AFTER && rsp_valid) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD_CYCLES;
            rsp_stall      <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (calm_left > 0) begin
            calm_left--;
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 99) == 0) begin
            calm_left = $urandom_range(50, 200);
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 99) < 70) begin
            rsp_stall <= 1'b0;
         end else begin
            stall_left = idle_len();
            rsp_stall  <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------

   int item_count    = 0;
   int digest_count  = 0;

   function automatic void add_beat(logic op, logic [7:0] data_byte, bit calm, bit drain);
      req_beat_type beat;
      beat.op         = op;
      beat.data_byte  = data_byte;
      beat.idle_after = calm ? 0 : idle_len();
      beat.wait_drain = drain;
      beat_q.push_back(beat);
      item_count++;
   endfunction

   // random bytes followed by a finish beat with a junk data byte
   function automatic void add_message(int len, bit calm, bit drain);
      for (int i = 0; i < len; i++) begin
         add_beat(OP_ABSORB, 8'($urandom_range(0, 255)), calm, drain && i == 0);
      end
      add_beat(OP_FINISH, 8'($urandom_range(0, 255)), calm, drain && len == 0);
      digest_count++;
   endfunction

   // message length, biased toward the padding boundaries
   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) begin
         return $urandom_range(0, 8);
      end else if (r < 55) begin
         return $urandom_range(9, 49);
      end else if (r < 75) begin
         return $urandom_range(50, 66);
      end else if (r < 90) begin
         case ($urandom_range(0, 3))
            0: begin
               return 55;
            end
            1: begin
               return 56;
            end
            2: begin
               return 63;
            end
            default: begin
               return 64;
            end
         endcase
      end
      return $urandom_range(67, 130);
   endfunction

   initial begin
      hash_restart();

      // empty message, finish carries a nonzero ignored byte
      add_beat(OP_FINISH, 8'hff, 1'b1, 1'b0);
      digest_count++;
      // "abc"
      add_beat(OP_ABSORB, 8'h61, 1'b0, 1'b0);
      add_beat(OP_ABSORB, 8'h62, 1'b0, 1'b0);
      add_beat(OP_ABSORB, 8'h63, 1'b0, 1'b0);
      add_beat(OP_FINISH, 8'h00, 1'b0, 1'b0);
      digest_count++;
      // byte extremes, each as a one-byte message
      add_beat(OP_ABSORB, 8'h00, 1'b1, 1'b0);
      add_beat(OP_FINISH, 8'h00, 1'b1, 1'b0);
      digest_count++;
      add_beat(OP_ABSORB, 8'hff, 1'b0, 1'b1);
      add_beat(OP_FINISH, 8'hff, 1'b0, 1'b0);
      digest_count++;
      // alternating extremes, sent only once the engine has drained
      add_beat(OP_ABSORB, 8'hff, 1'b0, 1'b1);
      add_beat(OP_ABSORB, 8'h00, 1'b0, 1'b0);
      add_beat(OP_FINISH, 8'h5a, 1'b0, 1'b0);
      digest_count++;

      // random messages; the length wrap at 2^64 bits cannot be reached
      while (item_count < ITEM_TARGET || digest_count < DIGEST_TARGET) begin
         add_message(pick_length(), $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // sample on the falling edge, clear of the driver and monitor updates
      @(negedge clock);
      while (beat_q.size() != 0 || req_valid || digest_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (TAIL_CYCLES) @(negedge clock);

      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // run-away guard
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: timeout with %0d digest words outstanding", $time, digest_q.size());
      $display("tb: failure");
      $finish;
   end

endmodule

[filelist.f]
hdl/sha1_pkg.sv
hdl/sha1_dpath.sv
hdl/sha1_ctrl.sv
hdl/sha1_hash_engine.sv
test/tb_sha1_hash_engine.sv
